[sv/e1pm_pkg.sv]
// package: constants, types and saturating helpers for the e1 performance monitor
package e1pm_pkg;

    localparam int HISTORY_DEPTH    = 96;
    localparam int INTERVAL_SECONDS = 900;
    localparam int RUN_SECONDS      = 10;
    localparam int COUNTER_BITS     = 32;
    localparam int NUM_COUNTERS     = 10;
    localparam int MINUTE_LEN       = 60;

    localparam int CNT_W   = COUNTER_BITS;
    localparam int SLOT_W  = $clog2(HISTORY_DEPTH);
    localparam int HCNT_W  = $clog2(HISTORY_DEPTH + 1);
    localparam int ELA_W   = $clog2(INTERVAL_SECONDS + 1);
    localparam int RUN_W   = $clog2(RUN_SECONDS + 1);
    localparam int IDX_W   = $clog2(NUM_COUNTERS);
    localparam int ADDR_W  = $clog2(HISTORY_DEPTH * NUM_COUNTERS);
    localparam int MIN_W   = $clog2(MINUTE_LEN + 1);
    localparam int CFG_IDX_W = 3;
    localparam int CFG_DATA_W = 16;

    typedef logic [CNT_W-1:0] t_cnt;

    // counter codes
    localparam logic [3:0] C_ES   = 4'd0;
    localparam logic [3:0] C_SES  = 4'd1;
    localparam logic [3:0] C_SEFS = 4'd2;
    localparam logic [3:0] C_UAS  = 4'd3;
    localparam logic [3:0] C_CSS  = 4'd4;
    localparam logic [3:0] C_PCV  = 4'd5;
    localparam logic [3:0] C_LES  = 4'd6;
    localparam logic [3:0] C_BES  = 4'd7;
    localparam logic [3:0] C_DM   = 4'd8;
    localparam logic [3:0] C_LCV  = 4'd9;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_BPV_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_PCV_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_AUS_MODE  = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_ADMIN     = 3'd3;

    // read sources
    localparam logic [1:0] SRC_CURRENT = 2'd0;
    localparam logic [1:0] SRC_TOTAL   = 2'd1;
    localparam logic [1:0] SRC_HISTORY = 2'd2;

    typedef enum logic [3:0] {
        S_IDLE, S_EXEC, S_CHECK, S_BC_RD, S_BC_WR,
        S_ROLL_START, S_ROLL_RD, S_ROLL_WR, S_READ_WAIT, S_OUT
    } t_state;

    typedef enum logic [1:0] { BC_NONE, BC_ENTER, BC_EXIT } t_bc;

    typedef enum logic [2:0] { HOP_ADD_K, HOP_SUB_K, HOP_ADD_ES, HOP_ADD_BES } t_hop;

    typedef struct packed {
        logic           lat_req;
        logic           exec;
        logic           bc_rd;
        logic           bc_wr;
        logic           roll_start;
        logic           roll_rd;
        logic           roll_wr;
        logic           roll_last;
        logic           rd_cap;
        logic [IDX_W-1:0] idx;
        t_hop           hop;
    } t_cmd;

    typedef struct packed {
        logic req_read;
        logic roll_due;
        t_bc  bc_kind;
    } t_sts;

    function automatic t_cnt sat_add(input t_cnt a, input t_cnt b);
        logic [CNT_W:0] s;
        s = {1'b0, a} + {1'b0, b};
        return s[CNT_W] ? {CNT_W{1'b1}} : s[CNT_W-1:0];
    endfunction

    function automatic t_cnt floor_sub(input t_cnt a, input t_cnt b);
        return (a > b) ? a - b : '0;
    endfunction

endpackage

[sv/e1pm_in_if.sv]
// interface: report and read request channel
interface e1pm_in_if;
    logic        valid;
    logic        ready;
    logic        req_type;
    logic        ses_flag;
    logic        es_flag;
    logic        bes_flag;
    logic        slip_flag;
    logic        frame_loss_flag;
    logic [15:0] bpv_errors;
    logic [15:0] pcv_errors;
    logic [1:0]  read_source;
    logic [6:0]  read_age;
    logic [3:0]  read_counter;

    modport source (output valid, req_type, ses_flag, es_flag, bes_flag, slip_flag,
                    frame_loss_flag, bpv_errors, pcv_errors, read_source, read_age,
                    read_counter, input ready);
    modport sink   (input valid, req_type, ses_flag, es_flag, bes_flag, slip_flag,
                    frame_loss_flag, bpv_errors, pcv_errors, read_source, read_age,
                    read_counter, output ready);
endinterface

[sv/e1pm_out_if.sv]
// interface: status and counter result channel
interface e1pm_out_if;
    logic        valid;
    logic        ready;
    logic        controller_up;
    logic        unavailable;
    logic        force_rai;
    logic [31:0] read_value;
    logic        read_valid;
    logic [9:0]  seconds_elapsed;
    logic [6:0]  valid_intervals;

    modport source (output valid, controller_up, unavailable, force_rai, read_value,
                    read_valid, seconds_elapsed, valid_intervals, input ready);
    modport sink   (input valid, controller_up, unavailable, force_rai, read_value,
                    read_valid, seconds_elapsed, valid_intervals, output ready);
endinterface

[sv/e1pm_ctrl.sv]
// controller: sequences report, back-correction, rollover and read steps
module e1pm_ctrl
    import e1pm_pkg::*;
(
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    input  t_sts i_sts,
    output t_cmd o_cmd
);
    t_state r_state, n_state;
    logic [IDX_W-1:0] r_idx, n_idx;
    logic bc_last, roll_last;

    assign bc_last   = (i_sts.bc_kind == BC_ENTER) ? (r_idx == IDX_W'(1)) : (r_idx == IDX_W'(2));
    assign roll_last = (r_idx == IDX_W'(NUM_COUNTERS - 1));

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_idx   <= '0;
        end else begin
            r_state <= n_state;
            r_idx   <= n_idx;
        end
    end

    always_comb begin
        n_state = r_state;
        n_idx   = r_idx;
        unique case (r_state)
            S_IDLE:  if (i_in_valid) n_state = S_EXEC;
            S_EXEC:  n_state = i_sts.req_read ? S_READ_WAIT : S_CHECK;
            S_CHECK: begin
                n_idx = '0;
                if (i_sts.bc_kind != BC_NONE) n_state = S_BC_RD;
                else if (i_sts.roll_due)      n_state = S_ROLL_START;
                else                          n_state = S_OUT;
            end
            S_BC_RD: n_state = S_BC_WR;
            S_BC_WR: begin
                if (bc_last) begin
                    n_idx   = '0;
                    n_state = i_sts.roll_due ? S_ROLL_START : S_OUT;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_BC_RD;
                end
            end
            S_ROLL_START: begin
                n_idx   = '0;
                n_state = S_ROLL_RD;
            end
            S_ROLL_RD: n_state = S_ROLL_WR;
            S_ROLL_WR: begin
                if (roll_last) begin
                    n_state = S_OUT;
                end else begin
                    n_idx   = r_idx + IDX_W'(1);
                    n_state = S_ROLL_RD;
                end
            end
            S_READ_WAIT: n_state = S_OUT;
            S_OUT:       if (i_out_ready) n_state = S_IDLE;
            default:     n_state = S_IDLE;
        endcase
    end

    always_comb begin
        o_cmd       = '0;
        o_cmd.idx   = r_idx;
        o_cmd.hop   = HOP_ADD_K;
        o_in_ready  = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready    = 1'b1;
                o_cmd.lat_req = i_in_valid;
            end
            S_EXEC:       o_cmd.exec = 1'b1;
            S_BC_RD, S_BC_WR: begin
                o_cmd.bc_rd = (r_state == S_BC_RD);
                o_cmd.bc_wr = (r_state == S_BC_WR);
                // enter: uas up, ses down; exit: uas down, es and bes restored
                if (i_sts.bc_kind == BC_ENTER) begin
                    o_cmd.hop = (r_idx == '0) ? HOP_ADD_K : HOP_SUB_K;
                end else begin
                    case (r_idx)
                        IDX_W'(0): o_cmd.hop = HOP_SUB_K;
                        IDX_W'(1): o_cmd.hop = HOP_ADD_ES;
                        default:   o_cmd.hop = HOP_ADD_BES;
                    endcase
                end
            end
            S_ROLL_START: o_cmd.roll_start = 1'b1;
            S_ROLL_RD:    o_cmd.roll_rd = 1'b1;
            S_ROLL_WR: begin
                o_cmd.roll_wr   = 1'b1;
                o_cmd.roll_last = roll_last;
            end
            S_READ_WAIT:  o_cmd.rd_cap = 1'b1;
            S_OUT:        o_out_valid = 1'b1;
            default: ;
        endcase
    end
endmodule

[sv/e1pm_dp.sv]
// datapath: counters, line state, minute tracking and history memory
module e1pm_dp
    import e1pm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  t_cmd                  i_cmd,
    output t_sts                  o_sts,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    input  logic                  i_req_type,
    input  logic                  i_ses_flag,
    input  logic                  i_es_flag,
    input  logic                  i_bes_flag,
    input  logic                  i_slip_flag,
    input  logic                  i_frame_loss_flag,
    input  logic [15:0]           i_bpv_errors,
    input  logic [15:0]           i_pcv_errors,
    input  logic [1:0]            i_read_source,
    input  logic [6:0]            i_read_age,
    input  logic [3:0]            i_read_counter,
    output logic                  o_controller_up,
    output logic                  o_unavailable,
    output logic                  o_force_rai,
    output logic [31:0]           o_read_value,
    output logic                  o_read_valid,
    output logic [9:0]            o_seconds_elapsed,
    output logic [6:0]            o_valid_intervals
);
    // configuration
    logic [15:0] r_bpv_limit, r_pcv_limit;
    logic        r_aus_mode, r_admin_down;

    // latched request
    logic        r_req_type, r_ses, r_es, r_bes, r_slip, r_fl;
    logic [15:0] r_bpv, r_pcv;
    logic [1:0]  r_src;
    logic [6:0]  r_age;
    logic [3:0]  r_cntsel;

    // state
    t_cnt r_cur [NUM_COUNTERS];
    t_cnt r_tot [NUM_COUNTERS];
    logic              r_unavail, r_line_up, r_rai;
    logic [RUN_W-1:0]  r_run;
    logic [15:0]       r_es_wf, r_bes_wf, r_es_prev, r_bes_prev;
    logic [MIN_W-1:0]  r_min_sec;
    logic [31:0]       r_min_bpv, r_min_pcv;
    logic [ELA_W-1:0]  r_elapsed;
    logic [HCNT_W-1:0] r_hcount;
    logic [SLOT_W-1:0] r_wslot;
    logic              r_roll_due;
    t_bc               r_bc_kind;
    logic [RUN_W-1:0]  r_bc_k;
    logic [31:0]       r_rd_value;
    logic              r_rd_valid;

    // history memory
    t_cnt              r_mem [HISTORY_DEPTH * NUM_COUNTERS];
    t_cnt              r_mem_q;
    logic [ADDR_W-1:0] mem_addr;
    logic              mem_rd, mem_wr;
    t_cnt              mem_wdata;

    // report step next values
    t_cnt              n_cur [NUM_COUNTERS];
    logic              n_unavail, n_line_up, n_rai;
    logic [RUN_W-1:0]  n_run;
    logic [15:0]       n_es_wf, n_bes_wf, n_es_prev, n_bes_prev;
    logic [MIN_W-1:0]  n_min_sec;
    logic [31:0]       n_min_bpv, n_min_pcv;
    logic [ELA_W-1:0]  n_elapsed;
    t_bc               n_bc_kind;
    logic [RUN_W-1:0]  n_bc_k;

    logic [RUN_W-1:0]  run_inc;
    logic              late_start;
    logic [32:0]       bpv_sum, pcv_sum;
    logic [31:0]       bpv_sat, pcv_sat;
    t_cnt              uas1, ses1;

    logic [SLOT_W-1:0] prev_slot, read_slot;
    logic [SLOT_W:0]   read_slot_raw;
    logic              age_ok, cnt_ok;
    logic [SLOT_W-1:0] addr_slot;
    logic [IDX_W-1:0]  addr_idx;
    t_cnt              roll_old;
    t_cnt              k_ext;

    assign run_inc    = r_run + RUN_W'(1);
    assign late_start = (r_elapsed >= ELA_W'(RUN_SECONDS - 1));
    assign bpv_sum    = {1'b0, r_min_bpv} + 33'(r_bpv);
    assign pcv_sum    = {1'b0, r_min_pcv} + 33'(r_pcv);
    assign bpv_sat    = bpv_sum[32] ? 32'hFFFF_FFFF : bpv_sum[31:0];
    assign pcv_sat    = pcv_sum[32] ? 32'hFFFF_FFFF : pcv_sum[31:0];
    assign uas1       = sat_add(r_cur[C_UAS], CNT_W'(1));
    assign ses1       = sat_add(r_cur[C_SES], CNT_W'(1));

    always_comb begin
        for (int i = 0; i < NUM_COUNTERS; i++) n_cur[i] = r_cur[i];
        n_unavail  = r_unavail;
        n_line_up  = r_line_up;
        n_rai      = r_rai;
        n_run      = r_run;
        n_es_wf    = r_es_wf;
        n_bes_wf   = r_bes_wf;
        n_es_prev  = r_es_prev;
        n_bes_prev = r_bes_prev;
        n_min_sec  = r_min_sec;
        n_min_bpv  = r_min_bpv;
        n_min_pcv  = r_min_pcv;
        n_elapsed  = r_elapsed + ELA_W'(1);
        n_bc_kind  = BC_NONE;
        n_bc_k     = RUN_W'(RUN_SECONDS - 1) - RUN_W'(r_elapsed);

        if (r_bpv != '0) begin
            n_cur[C_LES] = sat_add(r_cur[C_LES], CNT_W'(1));
            n_cur[C_LCV] = sat_add(r_cur[C_LCV], CNT_W'(r_bpv));
        end
        if (r_pcv != '0) n_cur[C_PCV] = sat_add(r_cur[C_PCV], CNT_W'(r_pcv));
        if (r_slip)      n_cur[C_CSS] = sat_add(r_cur[C_CSS], CNT_W'(1));
        if (r_fl)        n_cur[C_SEFS] = sat_add(r_cur[C_SEFS], CNT_W'(1));

        if (r_unavail) begin
            n_cur[C_UAS] = uas1;
            if (!r_ses) begin
                n_run = run_inc;
                if (run_inc >= RUN_W'(RUN_SECONDS)) begin
                    n_run     = '0;
                    n_unavail = 1'b0;
                    if (r_aus_mode)    n_rai = 1'b0;
                    if (!r_admin_down) n_line_up = 1'b1;
                    if (late_start) begin
                        n_cur[C_UAS] = floor_sub(uas1, CNT_W'(RUN_SECONDS));
                    end else begin
                        if (r_hcount != '0) n_bc_kind = BC_EXIT;
                        n_cur[C_UAS] = '0;
                    end
                    n_cur[C_ES]  = sat_add(r_cur[C_ES], CNT_W'(r_es_wf));
                    n_cur[C_BES] = sat_add(r_cur[C_BES], CNT_W'(r_bes_wf));
                end else begin
                    if (r_es && r_es_wf != 16'hFFFF)   n_es_wf  = r_es_wf + 16'd1;
                    if (r_bes && r_bes_wf != 16'hFFFF) n_bes_wf = r_bes_wf + 16'd1;
                end
            end else begin
                n_run      = '0;
                n_es_wf    = '0;
                n_bes_wf   = '0;
                n_es_prev  = '0;
                n_bes_prev = '0;
            end
        end else if (!r_ses) begin
            n_run = '0;
            if (r_es)  n_cur[C_ES]  = sat_add(r_cur[C_ES], CNT_W'(1));
            if (r_bes) n_cur[C_BES] = sat_add(r_cur[C_BES], CNT_W'(1));
            n_min_sec = r_min_sec + MIN_W'(1);
            n_min_bpv = bpv_sat;
            n_min_pcv = pcv_sat;
            if (n_min_sec >= MIN_W'(MINUTE_LEN)) begin
                if (pcv_sat > 32'(r_pcv_limit) || bpv_sat > 32'(r_bpv_limit))
                    n_cur[C_DM] = sat_add(r_cur[C_DM], CNT_W'(1));
                n_min_sec = '0;
                n_min_bpv = '0;
                n_min_pcv = '0;
            end
        end else begin
            n_cur[C_SES] = ses1;
            n_run = run_inc;
            if (run_inc >= RUN_W'(RUN_SECONDS)) begin
                n_run = '0;
                if (r_aus_mode) n_rai = 1'b1;
                n_line_up = 1'b0;
                if (late_start) begin
                    n_cur[C_UAS] = sat_add(r_cur[C_UAS], CNT_W'(RUN_SECONDS));
                    n_cur[C_SES] = floor_sub(ses1, CNT_W'(RUN_SECONDS));
                end else begin
                    if (r_hcount != '0) n_bc_kind = BC_ENTER;
                    n_cur[C_UAS] = CNT_W'(r_elapsed) + CNT_W'(1);
                    n_cur[C_SES] = '0;
                end
                n_unavail  = 1'b1;
                n_es_wf    = '0;
                n_bes_wf   = '0;
                n_es_prev  = '0;
                n_bes_prev = '0;
            end
        end
    end

    // history addressing
    assign prev_slot     = (r_wslot == '0) ? SLOT_W'(HISTORY_DEPTH - 1) : r_wslot - SLOT_W'(1);
    assign read_slot_raw = {1'b0, r_wslot} + (SLOT_W+1)'(HISTORY_DEPTH) - (SLOT_W+1)'(r_age);
    assign read_slot     = (read_slot_raw >= (SLOT_W+1)'(HISTORY_DEPTH))
                         ? SLOT_W'(read_slot_raw - (SLOT_W+1)'(HISTORY_DEPTH))
                         : read_slot_raw[SLOT_W-1:0];
    assign age_ok        = (r_age != '0) && (HCNT_W'(r_age) <= r_hcount);
    assign cnt_ok        = (r_cntsel < 4'(NUM_COUNTERS));

    always_comb begin
        addr_slot = r_wslot;
        addr_idx  = i_cmd.idx;
        if (i_cmd.bc_rd || i_cmd.bc_wr) begin
            addr_slot = prev_slot;
            case (i_cmd.hop)
                HOP_ADD_K, HOP_SUB_K: addr_idx = (r_bc_kind == BC_ENTER && i_cmd.hop == HOP_SUB_K)
                                                 ? IDX_W'(C_SES) : IDX_W'(C_UAS);
                HOP_ADD_ES:           addr_idx = IDX_W'(C_ES);
                default:              addr_idx = IDX_W'(C_BES);
            endcase
        end else if (i_cmd.exec) begin
            addr_slot = read_slot;
            addr_idx  = r_cntsel[IDX_W-1:0];
        end
    end

    assign mem_addr = ADDR_W'({addr_slot, 3'b000}) + ADDR_W'({addr_slot, 1'b0})
                    + ADDR_W'(addr_idx);
    assign mem_rd   = i_cmd.bc_rd || i_cmd.roll_rd
                    || (i_cmd.exec && r_req_type && r_src == SRC_HISTORY && age_ok && cnt_ok);
    assign mem_wr   = i_cmd.bc_wr || i_cmd.roll_wr;
    assign k_ext    = CNT_W'(r_bc_k);
    // an overwritten slot only holds data once the history has wrapped
    assign roll_old = (r_hcount == HCNT_W'(HISTORY_DEPTH)) ? r_mem_q : '0;

    always_comb begin
        mem_wdata = r_cur[i_cmd.idx];
        if (i_cmd.bc_wr) begin
            case (i_cmd.hop)
                HOP_ADD_K:   mem_wdata = sat_add(r_mem_q, k_ext);
                HOP_SUB_K:   mem_wdata = floor_sub(r_mem_q, k_ext);
                HOP_ADD_ES:  mem_wdata = sat_add(r_mem_q, CNT_W'(r_es_prev));
                default:     mem_wdata = sat_add(r_mem_q, CNT_W'(r_bes_prev));
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_rd) r_mem_q <= r_mem[mem_addr];
        if (mem_wr) r_mem[mem_addr] <= mem_wdata;
    end

    // latched request
    always_ff @(posedge i_clk) begin
        if (i_cmd.lat_req) begin
            r_req_type <= i_req_type;
            r_ses      <= i_ses_flag;
            r_es       <= i_es_flag;
            r_bes      <= i_bes_flag;
            r_slip     <= i_slip_flag;
            r_fl       <= i_frame_loss_flag;
            r_bpv      <= i_bpv_errors;
            r_pcv      <= i_pcv_errors;
            r_src      <= i_read_source;
            r_age      <= i_read_age;
            r_cntsel   <= i_read_counter;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_bpv_limit  <= 16'd122;
            r_pcv_limit  <= 16'd122;
            r_aus_mode   <= 1'b0;
            r_admin_down <= 1'b0;
            for (int i = 0; i < NUM_COUNTERS; i++) begin
                r_cur[i] <= '0;
                r_tot[i] <= '0;
            end
            r_unavail  <= 1'b0;
            r_line_up  <= 1'b0;
            r_rai      <= 1'b0;
            r_run      <= '0;
            r_es_wf    <= '0;
            r_bes_wf   <= '0;
            r_es_prev  <= '0;
            r_bes_prev <= '0;
            r_min_sec  <= '0;
            r_min_bpv  <= '0;
            r_min_pcv  <= '0;
            r_elapsed  <= '0;
            r_hcount   <= '0;
            r_wslot    <= '0;
            r_roll_due <= 1'b0;
            r_bc_kind  <= BC_NONE;
            r_bc_k     <= '0;
            r_rd_value <= '0;
            r_rd_valid <= 1'b0;
        end else begin
            if (i_cfg_we) begin
                unique case (i_cfg_index)
                    REG_BPV_LIMIT: r_bpv_limit <= i_cfg_data;
                    REG_PCV_LIMIT: r_pcv_limit <= i_cfg_data;
                    REG_AUS_MODE: begin
                        r_aus_mode <= i_cfg_data[0];
                        r_rai      <= i_cfg_data[0] & r_unavail;
                    end
                    REG_ADMIN: begin
                        r_admin_down <= i_cfg_data[0];
                        if (i_cfg_data[0]) r_line_up <= 1'b0;
                    end
                    default: ;
                endcase
            end
            if (i_cmd.exec) begin
                if (r_req_type) begin
                    r_bc_kind  <= BC_NONE;
                    r_roll_due <= 1'b0;
                end else begin
                    for (int i = 0; i < NUM_COUNTERS; i++) r_cur[i] <= n_cur[i];
                    r_unavail  <= n_unavail;
                    r_line_up  <= n_line_up;
                    r_rai      <= n_rai;
                    r_run      <= n_run;
                    r_es_wf    <= n_es_wf;
                    r_bes_wf   <= n_bes_wf;
                    r_es_prev  <= n_es_prev;
                    r_bes_prev <= n_bes_prev;
                    r_min_sec  <= n_min_sec;
                    r_min_bpv  <= n_min_bpv;
                    r_min_pcv  <= n_min_pcv;
                    r_elapsed  <= n_elapsed;
                    r_roll_due <= (n_elapsed >= ELA_W'(INTERVAL_SECONDS));
                    r_bc_kind  <= n_bc_kind;
                    r_bc_k     <= n_bc_k;
                    r_rd_value <= '0;
                    r_rd_valid <= 1'b0;
                end
            end
            if (i_cmd.rd_cap) begin
                r_rd_value <= '0;
                r_rd_valid <= 1'b0;
                if (cnt_ok) begin
                    if (r_src == SRC_CURRENT) begin
                        r_rd_value <= 32'(r_cur[r_cntsel[IDX_W-1:0]]);
                        r_rd_valid <= 1'b1;
                    end else if (r_src == SRC_TOTAL) begin
                        r_rd_value <= 32'(r_tot[r_cntsel[IDX_W-1:0]]);
                        r_rd_valid <= 1'b1;
                    end else if (r_src == SRC_HISTORY && age_ok) begin
                        r_rd_value <= 32'(r_mem_q);
                        r_rd_valid <= 1'b1;
                    end
                end
            end
            if (i_cmd.roll_start) begin
                if (r_unavail) begin
                    r_es_prev  <= r_es_wf;
                    r_bes_prev <= r_bes_wf;
                    r_es_wf    <= '0;
                    r_bes_wf   <= '0;
                end
                r_elapsed  <= '0;
                r_roll_due <= 1'b0;
            end
            if (i_cmd.roll_wr) begin
                r_tot[i_cmd.idx] <= sat_add(floor_sub(r_tot[i_cmd.idx], roll_old),
                                            r_cur[i_cmd.idx]);
                r_cur[i_cmd.idx] <= '0;
                if (i_cmd.roll_last) begin
                    if (r_hcount < HCNT_W'(HISTORY_DEPTH)) r_hcount <= r_hcount + HCNT_W'(1);
                    r_wslot <= (r_wslot == SLOT_W'(HISTORY_DEPTH - 1)) ? '0
                             : r_wslot + SLOT_W'(1);
                end
            end
        end
    end

    assign o_sts.req_read = r_req_type;
    assign o_sts.roll_due = r_roll_due;
    assign o_sts.bc_kind  = r_bc_kind;

    assign o_controller_up   = r_line_up;
    assign o_unavailable     = r_unavail;
    assign o_force_rai       = r_rai;
    assign o_read_value      = r_rd_value;
    assign o_read_valid      = r_rd_valid;
    assign o_seconds_elapsed = 10'(r_elapsed);
    assign o_valid_intervals = 7'(r_hcount);
endmodule

[sv/e1_performance_monitor.sv]
// top level: e1 line performance monitor with 15-minute history
//
// i_in carries one transaction per second of line status (req_type 0) or a
// counter read (req_type 1, by read_source, read_age and read_counter).
// o_out returns one transaction for every input: the controller, unavailable
// and remote alarm state, the selected counter with its valid flag, the
// seconds into the current interval and the count of completed intervals.
// One item is in flight at a time; i_in.ready is high only while idle.
// A read passes through the execute and read-capture states, a plain report
// through the execute and check states, before the result is offered. Entering
// the unavailable state early in an interval back-corrects two history counters
// and leaving it three, each with a read and a write; an interval boundary walks
// the ten counters through the single-port history memory one by one.
// Early back-correction and a boundary never fall in the same second.
// A result waits in o_out until taken; no new transaction is accepted meanwhile.
// Synchronous reset clears all counters, the line state and the history fill
// count; history entries are only read once written, so no clearing pass runs.
// Configuration writes (i_cfg_we, i_cfg_index, i_cfg_data) take effect at once.
module e1_performance_monitor
    import e1pm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    e1pm_in_if.sink               i_in,
    e1pm_out_if.source            o_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data
);
    t_cmd cmd;
    t_sts sts;

    e1pm_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_out.valid),
        .i_out_ready (o_out.ready),
        .i_sts       (sts),
        .o_cmd       (cmd)
    );

    e1pm_dp u_dp (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_cmd             (cmd),
        .o_sts             (sts),
        .i_cfg_we          (i_cfg_we),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data),
        .i_req_type        (i_in.req_type),
        .i_ses_flag        (i_in.ses_flag),
        .i_es_flag         (i_in.es_flag),
        .i_bes_flag        (i_in.bes_flag),
        .i_slip_flag       (i_in.slip_flag),
        .i_frame_loss_flag (i_in.frame_loss_flag),
        .i_bpv_errors      (i_in.bpv_errors),
        .i_pcv_errors      (i_in.pcv_errors),
        .i_read_source     (i_in.read_source),
        .i_read_age        (i_in.read_age),
        .i_read_counter    (i_in.read_counter),
        .o_controller_up   (o_out.controller_up),
        .o_unavailable     (o_out.unavailable),
        .o_force_rai       (o_out.force_rai),
        .o_read_value      (o_out.read_value),
        .o_read_valid      (o_out.read_valid),
        .o_seconds_elapsed (o_out.seconds_elapsed),
        .o_valid_intervals (o_out.valid_intervals)
    );
endmodule

[sv/e1pm_checker.sv]
// checker: port-level assertions for the performance monitor, bound to the top level
module e1pm_checker
    import e1pm_pkg::*;
(
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        i_in_ready,
    input logic        i_out_valid,
    input logic        i_out_ready,
    input logic        i_read_valid,
    input logic [31:0] i_read_value,
    input logic [9:0]  i_seconds_elapsed,
    input logic [6:0]  i_valid_intervals
);
    // a pending result holds until taken
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result dropped while stalled");

    // one transaction in flight
    a_no_overlap: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> !i_in_ready)
        else $error("input taken while result pending");

    a_elapsed_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid |-> (i_seconds_elapsed < 10'(INTERVAL_SECONDS)
                         && i_valid_intervals <= 7'(HISTORY_DEPTH)))
        else $error("interval position out of range");

    a_invalid_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_read_valid |-> i_read_value == '0)
        else $error("value on invalid read");

    a_reset_idle: assert property (@(posedge i_clk)
        !i_rst_n |=> !i_out_valid)
        else $error("result after reset");
endmodule

bind e1_performance_monitor e1pm_checker u_e1pm_checker (
    .i_clk             (i_clk),
    .i_rst_n           (i_rst_n),
    .i_in_ready        (i_in.ready),
    .i_out_valid       (o_out.valid),
    .i_out_ready       (o_out.ready),
    .i_read_valid      (o_out.read_valid),
    .i_read_value      (o_out.read_value),
    .i_seconds_elapsed (o_out.seconds_elapsed),
    .i_valid_intervals (o_out.valid_intervals)
);

[tb/e1pm_checker.sv]
// checker: predicts every monitor result from the accepted transactions and compares
module e1pm_scoreboard
    import e1pm_pkg::*;
(
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    e1pm_in_if                    i_in,
    e1pm_out_if                   i_out,
    input  logic                  i_cfg_we,
    input  logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  logic [CFG_DATA_W-1:0] i_cfg_data,
    output int                    o_errors,
    output int                    o_pending
);
    timeunit 1ns;
    timeprecision 1ps;

    typedef struct packed {
        logic        up;
        logic        unav;
        logic        rai;
        logic [31:0] value;
        logic        valid;
        logic [9:0]  secs;
        logic [6:0]  intervals;
    } t_status;

    t_status     expected_q[$];

    logic [15:0] bpv_limit, pcv_limit;
    logic        aus_mode, admin;
    t_cnt        cur[NUM_COUNTERS];
    t_cnt        tot[NUM_COUNTERS];
    t_cnt        hist[HISTORY_DEPTH*NUM_COUNTERS];
    logic        unav, up, rai;
    int          run_len, elapsed, hcount, wslot, min_secs;
    logic [15:0] es_fail, bes_fail, es_prev, bes_prev;
    logic [31:0] min_bpv, min_pcv;

    function automatic t_cnt add_clip(t_cnt a, longint unsigned b);
        longint unsigned s;
        s = a + b;
        return (s > 64'hFFFF_FFFF) ? '1 : s[31:0];
    endfunction

    function automatic t_cnt sub_clip(t_cnt a, longint unsigned b);
        return (a > b) ? t_cnt'(a - b) : '0;
    endfunction

    function automatic logic [15:0] inc16(logic [15:0] a);
        return (a == 16'hFFFF) ? a : a + 16'd1;
    endfunction

    function void clear_model();
        bpv_limit = 16'd122;
        pcv_limit = 16'd122;
        aus_mode  = 0;
        admin     = 0;
        foreach (cur[i]) begin
            cur[i] = '0;
            tot[i] = '0;
        end
        foreach (hist[i]) hist[i] = '0;
        {unav, up, rai} = '0;
        run_len = 0; elapsed = 0; hcount = 0; wslot = 0; min_secs = 0;
        {es_fail, bes_fail, es_prev, bes_prev} = '0;
        min_bpv = '0;
        min_pcv = '0;
    endfunction

    function void close_interval();
        int base;
        base = wslot * NUM_COUNTERS;
        if (unav) begin
            es_prev  = es_fail;
            bes_prev = bes_fail;
            es_fail  = '0;
            bes_fail = '0;
        end
        elapsed = 0;
        if (hcount < HISTORY_DEPTH) hcount++;
        wslot = (wslot + 1) % HISTORY_DEPTH;
        for (int i = 0; i < NUM_COUNTERS; i++) begin
            tot[i] = add_clip(sub_clip(tot[i], hist[base+i]), cur[i]);
            hist[base+i] = cur[i];
            cur[i] = '0;
        end
    endfunction

    function void account_second(logic ses, logic es, logic bes, logic slip, logic sef,
                                 logic [15:0] bpv, logic [15:0] pcv);
        int pslot;
        int back;
        pslot = (wslot == 0) ? HISTORY_DEPTH - 1 : wslot - 1;
        back  = RUN_SECONDS - 1 - elapsed;
        if (bpv != 0) begin
            cur[C_LES] = add_clip(cur[C_LES], 1);
            cur[C_LCV] = add_clip(cur[C_LCV], bpv);
        end
        if (pcv != 0) cur[C_PCV] = add_clip(cur[C_PCV], pcv);
        if (slip) cur[C_CSS] = add_clip(cur[C_CSS], 1);
        if (sef) cur[C_SEFS] = add_clip(cur[C_SEFS], 1);

        if (unav) begin
            cur[C_UAS] = add_clip(cur[C_UAS], 1);
            if (!ses) begin
                run_len++;
                if (run_len >= RUN_SECONDS) begin
                    // leaving unavailable: undo the run's UAS, restore ES and BES
                    run_len = 0;
                    unav = 0;
                    if (aus_mode) rai = 0;
                    if (!admin) up = 1;
                    if (elapsed >= RUN_SECONDS - 1) begin
                        cur[C_UAS] = sub_clip(cur[C_UAS], RUN_SECONDS);
                    end else begin
                        if (hcount != 0) begin
                            hist[pslot*NUM_COUNTERS+C_UAS] =
                                sub_clip(hist[pslot*NUM_COUNTERS+C_UAS], back);
                            hist[pslot*NUM_COUNTERS+C_ES] =
                                add_clip(hist[pslot*NUM_COUNTERS+C_ES], es_prev);
                            hist[pslot*NUM_COUNTERS+C_BES] =
                                add_clip(hist[pslot*NUM_COUNTERS+C_BES], bes_prev);
                        end
                        cur[C_UAS] = '0;
                    end
                    cur[C_ES]  = add_clip(cur[C_ES], es_fail);
                    cur[C_BES] = add_clip(cur[C_BES], bes_fail);
                end else begin
                    if (es) es_fail = inc16(es_fail);
                    if (bes) bes_fail = inc16(bes_fail);
                end
            end else begin
                run_len = 0;
                {es_fail, bes_fail, es_prev, bes_prev} = '0;
            end
        end else if (!ses) begin
            run_len = 0;
            if (es) cur[C_ES] = add_clip(cur[C_ES], 1);
            if (bes) cur[C_BES] = add_clip(cur[C_BES], 1);
            min_secs++;
            min_bpv = add_clip(min_bpv, bpv);
            min_pcv = add_clip(min_pcv, pcv);
            if (min_secs >= MINUTE_LEN) begin
                if (min_pcv > pcv_limit || min_bpv > bpv_limit)
                    cur[C_DM] = add_clip(cur[C_DM], 1);
                min_secs = 0;
                min_bpv = '0;
                min_pcv = '0;
            end
        end else begin
            cur[C_SES] = add_clip(cur[C_SES], 1);
            run_len++;
            if (run_len >= RUN_SECONDS) begin
                // entering unavailable: the run's SES become UAS
                run_len = 0;
                if (aus_mode) rai = 1;
                up = 0;
                if (elapsed >= RUN_SECONDS - 1) begin
                    cur[C_UAS] = add_clip(cur[C_UAS], RUN_SECONDS);
                    cur[C_SES] = sub_clip(cur[C_SES], RUN_SECONDS);
                end else begin
                    if (hcount != 0) begin
                        hist[pslot*NUM_COUNTERS+C_UAS] =
                            add_clip(hist[pslot*NUM_COUNTERS+C_UAS], back);
                        hist[pslot*NUM_COUNTERS+C_SES] =
                            sub_clip(hist[pslot*NUM_COUNTERS+C_SES], back);
                    end
                    cur[C_UAS] = t_cnt'(elapsed + 1);
                    cur[C_SES] = '0;
                end
                unav = 1;
                {es_fail, bes_fail, es_prev, bes_prev} = '0;
            end
        end
        elapsed++;
        if (elapsed >= INTERVAL_SECONDS) close_interval();
    endfunction

    function t_status predict_status();
        t_status r;
        r = '0;
        if (!i_in.req_type) begin
            account_second(i_in.ses_flag, i_in.es_flag, i_in.bes_flag, i_in.slip_flag,
                           i_in.frame_loss_flag, i_in.bpv_errors, i_in.pcv_errors);
        end else if (i_in.read_counter < NUM_COUNTERS) begin
            if (i_in.read_source == SRC_CURRENT) begin
                r.value = cur[i_in.read_counter];
                r.valid = 1;
            end else if (i_in.read_source == SRC_TOTAL) begin
                r.value = tot[i_in.read_counter];
                r.valid = 1;
            end else if (i_in.read_source == SRC_HISTORY && i_in.read_age >= 1
                         && i_in.read_age <= hcount) begin
                r.value = hist[((wslot + HISTORY_DEPTH - i_in.read_age) % HISTORY_DEPTH)
                               * NUM_COUNTERS + i_in.read_counter];
                r.valid = 1;
            end
        end
        r.up = up;
        r.unav = unav;
        r.rai = rai;
        r.secs = elapsed[9:0];
        r.intervals = hcount[6:0];
        return r;
    endfunction

    function void report_mismatch(string field, longint unsigned exp_v, longint unsigned got_v);
        o_errors++;
        if (o_errors <= 10)
            $display("%0t mismatch on %s: expected %0h, got %0h", $realtime, field, exp_v, got_v);
    endfunction

    initial begin
        o_errors = 0;
        clear_model();
    end

    assign o_pending = expected_q.size();

    always @(posedge i_clk) begin
        t_status e;
        if (!i_rst_n) begin
            clear_model();
            expected_q.delete();
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    REG_BPV_LIMIT: bpv_limit = i_cfg_data;
                    REG_PCV_LIMIT: pcv_limit = i_cfg_data;
                    REG_AUS_MODE: begin
                        aus_mode = i_cfg_data[0];
                        rai = aus_mode & unav;
                    end
                    REG_ADMIN: begin
                        admin = i_cfg_data[0];
                        if (admin) up = 0;
                    end
                    default: ;
                endcase
            end
            if (i_out.valid && i_out.ready) begin
                if (expected_q.size() == 0) begin
                    report_mismatch("unexpected transaction", 0, 1);
                end else begin
                    e = expected_q.pop_front();
                    if (e.up !== i_out.controller_up)
                        report_mismatch("controller_up", e.up, i_out.controller_up);
                    if (e.unav !== i_out.unavailable)
                        report_mismatch("unavailable", e.unav, i_out.unavailable);
                    if (e.rai !== i_out.force_rai)
                        report_mismatch("force_rai", e.rai, i_out.force_rai);
                    if (e.value !== i_out.read_value)
                        report_mismatch("read_value", e.value, i_out.read_value);
                    if (e.valid !== i_out.read_valid)
                        report_mismatch("read_valid", e.valid, i_out.read_valid);
                    if (e.secs !== i_out.seconds_elapsed)
                        report_mismatch("seconds_elapsed", e.secs, i_out.seconds_elapsed);
                    if (e.intervals !== i_out.valid_intervals)
                        report_mismatch("valid_intervals", e.intervals, i_out.valid_intervals);
                end
            end
            if (i_in.valid && i_in.ready)
                expected_q.push_back(predict_status());
        end
    end
endmodule

[tb/tb_top.sv]
// testbench top: stimulus, flow control and verdict for the e1 performance monitor
module tb_top;
    import e1pm_pkg::*;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int STALL_LIMIT = 5000;
    localparam int PHASE_ITEMS = 410;
    // an index past the last register, which the block ignores
    localparam logic [CFG_IDX_W-1:0] REG_UNUSED = 3'd5;

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_data;
    int                    errors, pending, sent;
    int                    quiet_cycles;
    bit                    hold_request, tx_calm;

    e1pm_in_if  in_ch();
    e1pm_out_if out_ch();

    e1_performance_monitor u_dut (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .o_out(out_ch),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data)
    );

    e1pm_scoreboard u_checker (
        .i_clk(i_clk), .i_rst_n(i_rst_n), .i_in(in_ch), .i_out(out_ch),
        .i_cfg_we(cfg_we), .i_cfg_index(cfg_index), .i_cfg_data(cfg_data),
        .o_errors(errors), .o_pending(pending)
    );

    initial begin
        i_clk = 0;
        forever #2 i_clk = ~i_clk;
    end

    // gaps after a transaction, mostly short and now and then long
    task automatic sender_gap();
        int n;
        if (!tx_calm && $urandom_range(0, 2) == 0) begin
            n = ($urandom_range(0, 9) == 0) ? $urandom_range(15, 60) : $urandom_range(1, 3);
            in_ch.valid <= 0;
            repeat (n) @(posedge i_clk);
        end
    endtask

    task automatic send(logic rtype, logic ses, logic es, logic bes, logic slip, logic sef,
                        logic [15:0] bpv, logic [15:0] pcv, logic [1:0] src,
                        logic [6:0] age, logic [3:0] cnt);
        in_ch.valid           <= 1;
        in_ch.req_type        <= rtype;
        in_ch.ses_flag        <= ses;
        in_ch.es_flag         <= es;
        in_ch.bes_flag        <= bes;
        in_ch.slip_flag       <= slip;
        in_ch.frame_loss_flag <= sef;
        in_ch.bpv_errors      <= bpv;
        in_ch.pcv_errors      <= pcv;
        in_ch.read_source     <= src;
        in_ch.read_age        <= age;
        in_ch.read_counter    <= cnt;
        do @(posedge i_clk); while (!in_ch.ready);
        sent++;
        if (sent == 600) hold_request = 1;
        if ($urandom_range(0, 99) == 0) tx_calm = !tx_calm;
        sender_gap();
    endtask

    function automatic logic [15:0] violations();
        case ($urandom_range(0, 5))
            0, 1: return 16'd0;
            2, 3: return 16'($urandom_range(1, 6));
            4: return 16'($urandom);
            default: return 16'hFFFF;
        endcase
    endfunction

    task automatic second_report(logic ses);
        send(0, ses, 1'($urandom_range(0, 1)), 1'($urandom_range(0, 1)),
             $urandom_range(0, 4) == 0, $urandom_range(0, 4) == 0, violations(), violations(),
             2'($urandom), 7'($urandom), 4'($urandom));
    endtask

    task automatic counter_read();
        logic [6:0] age;
        age = ($urandom_range(0, 7) == 0) ? 7'($urandom) : 7'($urandom_range(0, 3));
        send(1, 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom), 1'($urandom),
             16'($urandom), 16'($urandom),
             ($urandom_range(0, 9) == 0) ? 2'd3 : 2'($urandom_range(0, 2)), age,
             ($urandom_range(0, 7) == 0) ? 4'($urandom_range(10, 15))
                                         : 4'($urandom_range(0, 9)));
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
        cfg_we    <= 1;
        cfg_index <= idx;
        cfg_data  <= data;
        @(posedge i_clk);
    endtask

    task automatic settle();
        in_ch.valid <= 0;
        while (pending != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic configure(logic [15:0] bpv, logic [15:0] pcv, logic aus, logic adm);
        write_reg(REG_BPV_LIMIT, bpv);
        write_reg(REG_PCV_LIMIT, pcv);
        write_reg(REG_AUS_MODE, {15'd0, aus});
        write_reg(REG_ADMIN, {15'd0, adm});
        write_reg(REG_UNUSED, 16'hFFFF);
        cfg_we <= 0;
    endtask

    // flow control on the result side, with one long hold-off while items keep coming
    initial begin
        int stall;
        int calm_left;
        stall = 0;
        calm_left = 0;
        out_ch.ready <= 0;
        forever begin
            @(posedge i_clk);
            if (hold_request) begin
                hold_request = 0;
                out_ch.ready <= 0;
                repeat (500) @(posedge i_clk);
            end else if (stall > 0) begin
                stall--;
                out_ch.ready <= 0;
            end else if (calm_left > 0) begin
                calm_left--;
                out_ch.ready <= 1;
            end else if ($urandom_range(0, 149) == 0) begin
                calm_left = $urandom_range(50, 200);
                out_ch.ready <= 1;
            end else if ($urandom_range(0, 3) == 0) begin
                stall = ($urandom_range(0, 9) == 0) ? $urandom_range(20, 60)
                                                    : $urandom_range(0, 2);
                out_ch.ready <= 0;
            end else begin
                out_ch.ready <= 1;
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n || (in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= STALL_LIMIT) begin
            $display("Test completed with failures");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial begin
        int n;
        sent = 0;
        hold_request = 0;
        tx_calm = 0;
        quiet_cycles = 0;
        i_rst_n <= 0;
        cfg_we <= 0;
        cfg_index <= '0;
        cfg_data <= '0;
        in_ch.valid <= 0;
        in_ch.req_type <= 0;
        {in_ch.ses_flag, in_ch.es_flag, in_ch.bes_flag, in_ch.slip_flag,
         in_ch.frame_loss_flag} <= '0;
        in_ch.bpv_errors <= '0;
        in_ch.pcv_errors <= '0;
        in_ch.read_source <= '0;
        in_ch.read_age <= '0;
        in_ch.read_counter <= '0;
        repeat (9) @(posedge i_clk);
        i_rst_n <= 1;
        @(posedge i_clk);

        // directed: field extremes, entering and leaving unavailable, reads out of range
        send(0, 0, 1, 1, 1, 1, 16'hFFFF, 16'hFFFF, 2'd0, 7'd0, 4'd0);
        send(0, 0, 0, 0, 0, 0, 16'h0000, 16'h0000, 2'd3, 7'h7F, 4'hF);
        repeat (10) send(0, 1, 1, 1, 0, 1, 16'd1, 16'd1, 2'd0, 7'd0, 4'd0);
        repeat (10) send(0, 0, 1, 1, 1, 0, 16'd0, 16'd9, 2'd0, 7'd0, 4'd0);
        send(1, 0, 0, 0, 0, 0, 0, 0, SRC_CURRENT, 7'd0, C_UAS);
        send(1, 0, 0, 0, 0, 0, 0, 0, SRC_TOTAL, 7'd0, C_LCV);
        send(1, 0, 0, 0, 0, 0, 0, 0, SRC_HISTORY, 7'd1, C_ES);
        send(1, 0, 0, 0, 0, 0, 0, 0, 2'd3, 7'd96, 4'd15);
        settle();

        for (int phase = 0; phase < 4; phase++) begin
            case (phase)
                0: configure(16'd0, 16'd0, 1, 0);
                1: configure(16'hFFFF, 16'hFFFF, 0, 1);
                2: configure(16'($urandom_range(0, 400)), 16'($urandom_range(0, 400)), 1, 0);
                default: configure(16'd122, 16'd500, 0, 0);
            endcase
            n = 0;
            while (n < PHASE_ITEMS) begin
                case ($urandom_range(0, 9))
                    0, 1, 2: begin
                        // severely errored run, long enough most of the time
                        repeat ($urandom_range(7, 14)) begin second_report(1); n++; end
                    end
                    3, 4, 5: begin
                        repeat ($urandom_range(5, 16)) begin second_report(0); n++; end
                    end
                    6, 7: begin
                        repeat ($urandom_range(1, 5)) begin
                            second_report(1'($urandom_range(0, 1)));
                            n++;
                        end
                    end
                    default: begin
                        repeat ($urandom_range(1, 3)) begin counter_read(); n++; end
                    end
                endcase
            end
            settle();
        end

        if (errors == 0 && pending == 0) begin
            $display("Test completed successfully");
        end else begin
            $display("Test completed with failures");
        end
        $finish;
    end
endmodule
